// ===== rtl/sdrd_pkg.sv =====
// Shared types and constants for the SD card SPI command and block read sequencer.
package sdrd_pkg;

  // Operation codes carried by an input transfer
  localparam logic [1:0] OP_CMD  = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_XCHG = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_R1_EXPIRE = 2'd1;
  localparam logic [1:0] ST_TK_EXPIRE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_BLOCK_LENGTH   = 2'd0;
  localparam logic [1:0] REG_POLL_LIMIT     = 2'd1;
  localparam logic [1:0] REG_RESPONSE_BYTES = 2'd2;

  // Register reset values
  localparam logic [9:0] BLOCK_LENGTH_RST   = 10'd512;
  localparam logic [7:0] POLL_LIMIT_RST     = 8'd200;
  localparam logic [3:0] RESPONSE_BYTES_RST = 4'd8;

  // Bus bytes
  localparam logic [7:0] CMD17_BYTE = 8'h51;
  localparam logic [7:0] FILL_BYTE  = 8'hFF;
  localparam logic [7:0] R1_READY   = 8'h00;
  localparam logic [7:0] START_TOK  = 8'hFE;

  localparam logic [9:0] FRAME_BYTES = 10'd6;
  localparam logic [10:0] TAIL_BYTES = 11'd4;

  localparam int BLK_W  = 10;
  localparam int POLL_W = 8;
  localparam int RESP_W = 4;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_CMD_FRAME = 4'd1,
    PH_CMD_RESP = 4'd2,
    PH_RD_FRAME = 4'd3,
    PH_RD_R1    = 4'd4,
    PH_RD_TOKEN = 4'd5,
    PH_RD_DATA  = 4'd6,
    PH_RD_TAIL  = 4'd7
  } sdrd_phase_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  command_byte;
    logic [31:0] argument;
    logic [7:0]  crc_byte;
    logic [22:0] sector;
    logic [7:0]  rx_byte;
  } sdrd_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       data_last;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] response;
  } sdrd_result_t;

  // Effective (clamped) limits handed from the register file to the sequencer
  typedef struct packed {
    logic [BLK_W-1:0]  blk;
    logic [POLL_W-1:0] poll;
    logic [RESP_W-1:0] resp;
  } sdrd_limits_t;

endpackage

// ===== rtl/sdrd_cfg.sv =====
// Configuration registers and clamping of the limits they hold.
module sdrd_cfg import sdrd_pkg::*; #(
  parameter int MAX_BLOCK          = 512,
  parameter int MAX_RESPONSE_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [BLK_W-1:0]   wr_data,
  output sdrd_limits_t       lim
);

  logic [BLK_W-1:0]  block_length_r;
  logic [POLL_W-1:0] poll_limit_r;
  logic [RESP_W-1:0] response_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_length_r   <= BLOCK_LENGTH_RST;
      poll_limit_r     <= POLL_LIMIT_RST;
      response_bytes_r <= RESPONSE_BYTES_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BLOCK_LENGTH:   block_length_r   <= wr_data;
        REG_POLL_LIMIT:     poll_limit_r     <= wr_data[POLL_W-1:0];
        REG_RESPONSE_BYTES: response_bytes_r <= wr_data[RESP_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one; block length and response bytes over their maximum act as the maximum
  always_comb begin
    lim.blk = block_length_r;
    if (block_length_r == '0) begin
      lim.blk = BLK_W'(1);
    end else if (32'(block_length_r) > MAX_BLOCK) begin
      lim.blk = BLK_W'(MAX_BLOCK);
    end
    lim.poll = (poll_limit_r == '0) ? POLL_W'(1) : poll_limit_r;
    lim.resp = response_bytes_r;
    if (response_bytes_r == '0) begin
      lim.resp = RESP_W'(1);
    end else if (32'(response_bytes_r) > MAX_RESPONSE_BYTES) begin
      lim.resp = RESP_W'(MAX_RESPONSE_BYTES);
    end
  end

endmodule

// ===== rtl/sdrd_seq.sv =====
// Phase machine: turns one registered event into the next bus byte and status.
module sdrd_seq import sdrd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  sdrd_item_t   item,
  input  sdrd_limits_t lim,
  output logic         res_valid,
  output sdrd_result_t result
);

  sdrd_phase_t phase_r, phase_nxt;
  logic [47:0] frame_r, frame_nxt;
  logic [9:0]  byte_cnt_r, byte_cnt_nxt;
  logic [7:0]  poll_cnt_r, poll_cnt_nxt;
  logic [7:0]  last_resp_r, last_resp_nxt;
  logic [1:0]  err_r, err_nxt;

  logic [10:0] byte_inc;
  logic [8:0]  poll_inc;
  logic [7:0]  tx;
  logic        done;

  assign byte_inc = {1'b0, byte_cnt_r} + 11'd1;
  assign poll_inc = {1'b0, poll_cnt_r} + 9'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      frame_r     <= '0;
      byte_cnt_r  <= '0;
      poll_cnt_r  <= '0;
      last_resp_r <= '0;
      err_r       <= ST_OK;
    end else if (go) begin
      phase_r     <= phase_nxt;
      frame_r     <= frame_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      poll_cnt_r  <= poll_cnt_nxt;
      last_resp_r <= last_resp_nxt;
      err_r       <= err_nxt;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    frame_nxt     = frame_r;
    byte_cnt_nxt  = byte_cnt_r;
    poll_cnt_nxt  = poll_cnt_r;
    last_resp_nxt = last_resp_r;
    err_nxt       = err_r;
    tx            = FILL_BYTE;
    done          = 1'b0;
    res_valid     = 1'b1;
    result        = '0;

    unique case (item.operation)
      OP_CMD, OP_READ: begin
        if (phase_r != PH_IDLE) begin
          res_valid = 1'b0;          // start while busy is dropped
        end else begin
          err_nxt       = ST_OK;
          last_resp_nxt = '0;
          poll_cnt_nxt  = '0;
          if (item.operation == OP_CMD) begin
            tx        = item.command_byte;
            frame_nxt = {item.argument, item.crc_byte, 8'h00};
            phase_nxt = PH_CMD_FRAME;
          end else begin
            tx        = CMD17_BYTE;
            frame_nxt = {item.sector, 9'h000, FILL_BYTE, 8'h00};
            phase_nxt = PH_RD_FRAME;
          end
          byte_cnt_nxt = 10'd1;
        end
      end
      OP_XCHG: begin
        unique case (phase_r)
          PH_CMD_FRAME, PH_RD_FRAME: begin
            if (byte_cnt_r < FRAME_BYTES) begin
              tx           = frame_r[47:40];
              frame_nxt    = {frame_r[39:0], 8'h00};
              byte_cnt_nxt = byte_inc[9:0];
            end else begin
              byte_cnt_nxt = '0;
              poll_cnt_nxt = '0;
              phase_nxt    = (phase_r == PH_CMD_FRAME) ? PH_CMD_RESP : PH_RD_R1;
            end
          end
          PH_CMD_RESP: begin
            if (item.rx_byte != FILL_BYTE) begin
              last_resp_nxt = item.rx_byte;
            end
            byte_cnt_nxt = byte_inc[9:0];
            if (byte_inc >= {7'd0, lim.resp}) begin
              done            = 1'b1;
              result.response = last_resp_nxt;
            end
          end
          PH_RD_R1: begin
            poll_cnt_nxt = poll_inc[7:0];
            if (item.rx_byte == R1_READY) begin
              phase_nxt    = PH_RD_TOKEN;
              poll_cnt_nxt = '0;
            end else if (poll_inc >= {1'b0, lim.poll}) begin
              if (err_r == ST_OK) err_nxt = ST_R1_EXPIRE;
              phase_nxt    = PH_RD_TOKEN;
              poll_cnt_nxt = '0;
            end
          end
          PH_RD_TOKEN: begin
            poll_cnt_nxt = poll_inc[7:0];
            if (item.rx_byte == START_TOK) begin
              phase_nxt    = PH_RD_DATA;
              byte_cnt_nxt = '0;
            end else if (poll_inc >= {1'b0, lim.poll}) begin
              if (err_r == ST_OK) err_nxt = ST_TK_EXPIRE;
              phase_nxt    = PH_RD_DATA;
              byte_cnt_nxt = '0;
            end
          end
          PH_RD_DATA: begin
            result.data_valid = 1'b1;
            result.data_byte  = item.rx_byte;
            byte_cnt_nxt      = byte_inc[9:0];
            if (byte_inc >= {1'b0, lim.blk}) begin
              result.data_last = 1'b1;
              phase_nxt        = PH_RD_TAIL;
              byte_cnt_nxt     = '0;
            end
          end
          PH_RD_TAIL: begin
            byte_cnt_nxt = byte_inc[9:0];
            if (byte_inc >= TAIL_BYTES) done = 1'b1;
          end
          default: res_valid = 1'b0;  // exchange while idle
        endcase
      end
      default: res_valid = 1'b0;      // unused operation code
    endcase

    if (done) begin
      phase_nxt    = PH_IDLE;
      byte_cnt_nxt = '0;
      poll_cnt_nxt = '0;
    end
    result.tx_valid    = !done;
    result.tx_byte     = done ? 8'h00 : tx;
    result.chip_select = !done;
    result.done_res    = done;
    result.status      = err_nxt;
  end

endmodule

// ===== rtl/sd_spi_command_and_block_read.sv =====
// Top level of the SD card SPI command and single-block read sequencer.
// Usage:
//  - in_*: one transfer per event. Operation 0 starts a generic command frame,
//    1 starts a CMD17 block read of the given sector, 2 reports that the SPI
//    byte last requested has been exchanged (rx_byte holds what came back).
//  - out_*: one result transfer per event that is acted upon; starts while
//    busy, exchanges while idle and operation code 3 give none. A result
//    carries the next byte to send, chip select, any block data byte and,
//    on the final result, done_res with status and (generic command) response.
//  - cfg_*: register writes, always ready; write only while the block is idle.
// Timing: an event is held in the input register and its result is registered
//  in the output register when the event advances. The phase machine handles
//  each event combinationally, giving one transfer per cycle unless stalled.
// Stalls: while the output register holds an untaken result the input register
//  keeps its event and in_ready follows; in_ready stays high when the input
//  register is empty or moving on.
// Reset (rst_n low, synchronous): phase idle, counters and status cleared,
//  registers back to block length 512, poll limit 200, response bytes 8.
module sd_spi_command_and_block_read import sdrd_pkg::*; #(
  parameter int MAX_BLOCK          = 512,
  parameter int MAX_RESPONSE_BYTES = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sdrd_item_t       in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output sdrd_result_t     out_result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [BLK_W-1:0] cfg_data
);

  sdrd_limits_t lim;
  sdrd_item_t   s1_item_r;
  logic         s1_valid_r, s1_valid_nxt;
  logic         out_valid_r, out_valid_nxt;
  sdrd_result_t out_result_r;
  logic         advance;
  logic         res_valid;
  sdrd_result_t result;

  assign cfg_ready = 1'b1;

  sdrd_cfg #(
    .MAX_BLOCK          (MAX_BLOCK),
    .MAX_RESPONSE_BYTES (MAX_RESPONSE_BYTES)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .lim      (lim)
  );

  // event leaves the input register when the result slot is free or being taken
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  assign s1_valid_nxt  = in_valid || (s1_valid_r && !advance);
  assign out_valid_nxt = advance ? res_valid : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_ready ? s1_valid_nxt : s1_valid_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
    if (advance && res_valid) begin
      out_result_r <= result;
    end
  end

  sdrd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (advance),
    .item      (s1_item_r),
    .lim       (lim),
    .res_valid (res_valid),
    .result    (result)
  );

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule
